FILE: design/gflpe_pkg.sv
// shared types, field tables and modular helpers for the gf(2^8) log-domain evaluator
package gflpe_pkg;

    typedef logic [7:0] gf_t;
    typedef logic [255:0][7:0] gf_table_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } pipe_adv_t;

    localparam int NUM_COEFS = 8;
    localparam gf_t ZERO_LOG = 8'd255;
    localparam gf_t FIELD_LOW = 8'd113;

    function automatic gf_t gf_shift(gf_t v);
        gf_t r;
        r = {v[6:0], 1'b0};
        if (v[7]) begin
            r = r ^ FIELD_LOW;
        end
        return r;
    endfunction

    function automatic gf_table_t build_exp_table();
        gf_table_t t;
        gf_t v;
        t = '0;
        v = 8'd1;
        for (int k = 0; k < 255; k++) begin
            t[k] = v;
            v = gf_shift(v);
        end
        t[255] = 8'd0;
        return t;
    endfunction

    function automatic gf_table_t build_log_table();
        gf_table_t t;
        gf_t v;
        t = '0;
        t[0] = ZERO_LOG;
        v = 8'd1;
        for (int k = 0; k < 255; k++) begin
            t[v] = k[7:0];
            v = gf_shift(v);
        end
        return t;
    endfunction

    localparam gf_table_t EXP_TABLE = build_exp_table();
    localparam gf_table_t LOG_TABLE = build_log_table();

    // 256 == 1 mod 255, so fold the high bits onto the low byte
    function automatic gf_t mod255_fold(logic [10:0] p);
        logic [8:0] s;
        s = 9'(p[7:0]) + 9'(p[10:8]);
        if (s >= 9'd255) begin
            s = s - 9'd255;
        end
        return s[7:0];
    endfunction

    function automatic gf_t mod255_add(gf_t a, gf_t b);
        logic [8:0] s;
        s = 9'(a) + 9'(b);
        if (s >= 9'd255) begin
            s = s - 9'd255;
        end
        return s[7:0];
    endfunction

endpackage

FILE: design/gf256_log_domain_poly_eval.sv
// top level of the gf(2^8) log-domain polynomial evaluator
//
//  channel   direction  content
//  s_        in         x_log, y_log
//  m_        out        value_log, on_curve
//  apb       in/out     coef_0 .. coef_7 at byte address 4*i
//
// five register stages; one point per cycle while the output is not stalled
// the rate is set by the per-stage handshake; a stage advances only when it is empty or the next stage advances
// reset clears the valid bits and the coefficients, data registers are not reset
// a stalled output holds; earlier empty stages keep filling until the pipe is full
module gf256_log_domain_poly_eval import gflpe_pkg::*; #(
    parameter int DEGREE = 7
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // x_log[7:0], y_log[15:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // value_log[7:0], on_curve[8], zero fill
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NT = DEGREE + 1;
    localparam int NS = 5;

    gf_t       coef [NUM_COEFS];
    gf_t       term [NT];
    gf_t       y3;
    logic      z3;
    gf_t       value_log;
    logic      on_curve;
    logic [NS:1] vld_reg;
    logic [NS:1] vld_next;
    logic [NS:1] rdy;
    logic [NS:0] vin;
    pipe_adv_t adv;

    gflpe_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    always_comb begin
        rdy[NS] = !vld_reg[NS] || m_tready;
        for (int k = NS - 1; k >= 1; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        vin = {vld_reg, s_tvalid};
        for (int k = 1; k <= NS; k++) begin
            vld_next[k] = rdy[k] ? vin[k-1] : vld_reg[k];
        end
    end

    assign adv = '{s1: rdy[1], s2: rdy[2], s3: rdy[3], s4: rdy[4], s5: rdy[5]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    gflpe_terms #(.DEGREE(DEGREE)) u_terms (
        .aclk     (aclk),
        .adv      (adv),
        .x_log    (s_tdata[7:0]),
        .y_log    (s_tdata[15:8]),
        .coef     (coef),
        .term     (term),
        .y_out    (y3),
        .zero_out (z3)
    );

    gflpe_reduce #(.DEGREE(DEGREE)) u_reduce (
        .aclk      (aclk),
        .adv       (adv),
        .term      (term),
        .y_in      (y3),
        .zero_in   (z3),
        .value_log (value_log),
        .on_curve  (on_curve)
    );

    assign s_tready = rdy[1];
    assign m_tvalid = vld_reg[NS];
    assign m_tdata  = {7'd0, on_curve, value_log};

endmodule

FILE: design/gflpe_cfg.sv
// apb register file holding the log-form coefficients
module gflpe_cfg import gflpe_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output gf_t         coef [NUM_COEFS]
);

    gf_t coef_reg [NUM_COEFS];
    logic [2:0] index;

    assign index = paddr[4:2];
    assign pready = 1'b1;
    assign prdata = {24'd0, coef_reg[index]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_COEFS; i++) begin
                coef_reg[i] <= 8'd0;
            end
        end else if (psel && penable && pwrite && pready) begin
            coef_reg[index] <= pwdata[7:0];
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_COEFS; i++) begin
            coef[i] = coef_reg[i];
        end
    end

endmodule

FILE: design/gflpe_terms.sv
// stages one to three: point powers, term exponents and antilog lookup
module gflpe_terms import gflpe_pkg::*; #(
    parameter int DEGREE = 7
) (
    input  logic      aclk,
    input  pipe_adv_t adv,
    input  gf_t       x_log,
    input  gf_t       y_log,
    input  gf_t       coef [NUM_COEFS],
    output gf_t       term [DEGREE+1],
    output gf_t       y_out,
    output logic      zero_out
);

    localparam int NT = DEGREE + 1;

    gf_t  xk_reg [NT];
    gf_t  y1_reg;
    logic z1_reg;

    gf_t  e_reg [NT];
    logic cz_reg [NT];
    gf_t  y2_reg;
    logic z2_reg;

    gf_t  t_reg [NT];
    gf_t  y3_reg;
    logic z3_reg;

    // x times k mod 255 for each power k
    always_ff @(posedge aclk) begin
        if (adv.s1) begin
            for (int k = 0; k < NT; k++) begin
                xk_reg[k] <= mod255_fold(11'(x_log) * 11'(k));
            end
            y1_reg <= y_log;
            z1_reg <= (x_log == ZERO_LOG);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv.s2) begin
            for (int i = 0; i < NT; i++) begin
                e_reg[i]  <= mod255_add(coef[i], xk_reg[DEGREE-i]);
                cz_reg[i] <= (coef[i] == ZERO_LOG);
            end
            y2_reg <= y1_reg;
            z2_reg <= z1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv.s3) begin
            for (int i = 0; i < NT; i++) begin
                t_reg[i] <= cz_reg[i] ? 8'd0 : EXP_TABLE[e_reg[i]];
            end
            y3_reg <= y2_reg;
            z3_reg <= z2_reg;
        end
    end

    always_comb begin
        for (int i = 0; i < NT; i++) begin
            term[i] = t_reg[i];
        end
    end

    assign y_out = y3_reg;
    assign zero_out = z3_reg;

endmodule

FILE: design/gflpe_reduce.sv
// stages four and five: term sum, log lookup and candidate compare
module gflpe_reduce import gflpe_pkg::*; #(
    parameter int DEGREE = 7
) (
    input  logic      aclk,
    input  pipe_adv_t adv,
    input  gf_t       term [DEGREE+1],
    input  gf_t       y_in,
    input  logic      zero_in,
    output gf_t       value_log,
    output logic      on_curve
);

    localparam int NT = DEGREE + 1;

    gf_t  sum_next;
    gf_t  sum_reg;
    gf_t  y4_reg;
    logic z4_reg;
    gf_t  val_next;
    gf_t  val_reg;
    logic hit_reg;

    always_comb begin
        sum_next = 8'd0;
        for (int i = 0; i < NT; i++) begin
            sum_next = sum_next ^ term[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv.s4) begin
            sum_reg <= sum_next;
            y4_reg  <= y_in;
            z4_reg  <= zero_in;
        end
    end

    assign val_next = z4_reg ? ZERO_LOG : LOG_TABLE[sum_reg];

    always_ff @(posedge aclk) begin
        if (adv.s5) begin
            val_reg <= val_next;
            hit_reg <= (y4_reg == val_next);
        end
    end

    assign value_log = val_reg;
    assign on_curve = hit_reg;

endmodule
